// ===== design/lcttl_pkg.sv =====
// shared types and constants for the lru cache with time-to-live
// no dependencies
package lcttl_pkg;

    typedef enum logic [2:0] {
        MODE_PUT    = 3'd0,
        MODE_GET    = 3'd1,
        MODE_REMOVE = 3'd2,
        MODE_CLEAR  = 3'd3,
        MODE_TICK   = 3'd4
    } t_mode;

    typedef enum logic {
        CFG_ENTRY_LIMIT = 1'b0,
        CFG_LIFETIME    = 1'b1
    } t_cfg_index;

    localparam logic [15:0] DEFAULT_LIFETIME = 16'd300;
    localparam logic [4:0]  RESET_LIMIT      = 5'd16;

    typedef struct packed {
        logic [2:0]  mode;
        logic [63:0] lookup_key;
        logic [63:0] store_value;
    } t_req;

    typedef struct packed {
        logic        hit;
        logic [63:0] read_value;
        logic        evicted;
        logic [4:0]  live_count;
    } t_rsp;

endpackage

// ===== design/lru_cache_with_ttl.sv =====
// top level of the lru cache with time-to-live
// depends on lcttl_pkg and lcttl_order
//
// channel   direction  ports                              handshake
// request   in         i_req                              start & !busy
// result    out        o_rsp                              o_result_strobe
// config    in         i_cfg_index, i_cfg_data            i_cfg_we
//
// a request is registered, then looked up, updated and answered in the next
// cycle; start reaches the strobe through r_req_valid and o_result_strobe;
// one request per cycle, set by the combinational key compare and lru pick
// over all slots; busy stays low; the receiver cannot stall the result strobe
// reset clears valid bits, time and the strobe; configuration goes to defaults
module lru_cache_with_ttl #(
    parameter int ENTRIES    = 16,
    parameter int KEY_BITS   = 64,
    parameter int VALUE_BITS = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  lcttl_pkg::t_req  i_req,
    input  logic             i_cfg_we,
    input  logic             i_cfg_index,
    input  logic [15:0]      i_cfg_data,
    output logic             o_result_strobe,
    output lcttl_pkg::t_rsp  o_rsp
);

    localparam int CW = $clog2(ENTRIES + 1);

    logic                  r_req_valid;
    lcttl_pkg::t_req       r_req;
    logic [4:0]            r_limit;
    logic [15:0]           r_life;
    logic [31:0]           r_now;
    logic [ENTRIES-1:0]    r_valid;
    logic [KEY_BITS-1:0]   r_key   [ENTRIES];
    logic [VALUE_BITS-1:0] r_value [ENTRIES];
    logic [31:0]           r_exp   [ENTRIES];

    logic [31:0]           now_eff;
    logic [31:0]           fresh;
    logic [ENTRIES-1:0]    live;
    logic [ENTRIES-1:0]    match;
    logic [ENTRIES-1:0]    lru;
    logic [ENTRIES-1:0]    evict;
    logic [ENTRIES-1:0]    free_slot;
    logic [ENTRIES-1:0]    touch;
    logic [ENTRIES-1:0]    wr_key;
    logic [ENTRIES-1:0]    wr_val;
    logic [ENTRIES-1:0]    wr_exp;
    logic [ENTRIES-1:0]    n_valid;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] val;
    logic [VALUE_BITS-1:0] hit_val;
    logic [CW-1:0]         live_n;
    logic [CW-1:0]         lim;
    logic [CW-1:0]         cnt_after;
    logic                  any_hit;
    logic                  found;
    lcttl_pkg::t_rsp       n_rsp;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_valid <= 1'b0;
            r_limit     <= lcttl_pkg::RESET_LIMIT;
            r_life      <= lcttl_pkg::DEFAULT_LIFETIME;
        end else begin
            r_req_valid <= start && !busy;
            if (i_cfg_we) begin
                unique case (lcttl_pkg::t_cfg_index'(i_cfg_index))
                    lcttl_pkg::CFG_ENTRY_LIMIT: r_limit <= i_cfg_data[4:0];
                    lcttl_pkg::CFG_LIFETIME:    r_life  <= i_cfg_data;
                    default:                    r_life  <= r_life;
                endcase
            end
        end
        if (start && !busy) begin
            r_req <= i_req;
        end
    end

    assign key     = r_req.lookup_key[KEY_BITS-1:0];
    assign val     = r_req.store_value[VALUE_BITS-1:0];
    assign now_eff = (r_req.mode == lcttl_pkg::MODE_TICK) ? r_now + 32'd1 : r_now;
    assign fresh   = now_eff + {16'd0, (r_life == '0) ? lcttl_pkg::DEFAULT_LIFETIME : r_life};

    // drop expired entries first, then compare keys among what is left
    always_comb begin
        logic [31:0] d;
        for (int i = 0; i < ENTRIES; i++) begin
            d        = r_exp[i] - now_eff;
            live[i]  = r_valid[i] && (d != '0) && !d[31];
            match[i] = live[i] && (r_key[i] == key);
        end
    end

    always_comb begin
        hit_val = '0;
        live_n  = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            hit_val = hit_val | (match[i] ? r_value[i] : '0);
            live_n  = live_n + CW'(live[i]);
        end
        any_hit = |match;
        if (r_limit == '0 || 32'(r_limit) > ENTRIES) begin
            lim = CW'(ENTRIES);
        end else begin
            lim = CW'(r_limit);
        end
    end

    lcttl_order #(
        .ENTRIES (ENTRIES)
    ) u_order (
        .i_clk   (i_clk),
        .i_live  (live),
        .i_touch (r_req_valid ? touch : '0),
        .o_lru   (lru)
    );

    always_comb begin
        evict = (!any_hit && live_n >= lim) ? lru : '0;
        free_slot = '0;
        found     = 1'b0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (!found && !(live[i] && !evict[i])) begin
                free_slot[i] = 1'b1;
                found        = 1'b1;
            end
        end
    end

    always_comb begin
        n_valid   = live;
        touch     = '0;
        wr_key    = '0;
        wr_val    = '0;
        wr_exp    = '0;
        cnt_after = live_n;
        n_rsp     = '0;
        unique case (lcttl_pkg::t_mode'(r_req.mode))
            lcttl_pkg::MODE_PUT: begin
                n_rsp.hit = any_hit;
                if (any_hit) begin
                    touch  = match;
                    wr_val = match;
                    wr_exp = match;
                end else begin
                    n_rsp.evicted = |evict;
                    n_valid       = (live & ~evict) | free_slot;
                    touch         = free_slot;
                    wr_key        = free_slot;
                    wr_val        = free_slot;
                    wr_exp        = free_slot;
                    cnt_after     = live_n + CW'(1) - CW'(|evict);
                end
            end
            lcttl_pkg::MODE_GET: begin
                n_rsp.hit = any_hit;
                n_rsp.read_value = 64'(hit_val);
                touch  = match;
                wr_exp = match;
            end
            lcttl_pkg::MODE_REMOVE: begin
                n_rsp.hit = any_hit;
                n_valid   = live & ~match;
                cnt_after = live_n - CW'(any_hit);
            end
            lcttl_pkg::MODE_CLEAR: begin
                n_valid   = '0;
                cnt_after = '0;
            end
            lcttl_pkg::MODE_TICK: begin
                n_valid = live;
            end
            default: begin
                n_valid = live;
            end
        endcase
        n_rsp.live_count = 5'(cnt_after);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid         <= '0;
            r_now           <= '0;
            o_result_strobe <= 1'b0;
        end else begin
            o_result_strobe <= r_req_valid;
            if (r_req_valid) begin
                r_valid <= n_valid;
                r_now   <= now_eff;
            end
        end
        if (r_req_valid) begin
            o_rsp <= n_rsp;
            for (int i = 0; i < ENTRIES; i++) begin
                if (wr_key[i]) begin
                    r_key[i] <= key;
                end
                if (wr_val[i]) begin
                    r_value[i] <= val;
                end
                if (wr_exp[i]) begin
                    r_exp[i] <= fresh;
                end
            end
        end
    end

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> ##1 o_result_strobe)
        else $error("accepted request produced no result");

    a_evict_not_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_strobe && o_rsp.evicted) |-> !o_rsp.hit)
        else $error("eviction reported on a hit");

    a_value_needs_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_strobe && o_rsp.read_value != '0) |-> o_rsp.hit)
        else $error("read value without a hit");

    a_lru_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_req_valid |-> $onehot0(lru))
        else $error("more than one least recently used slot");

    a_key_unique: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_req_valid |-> $onehot0(match))
        else $error("key held in more than one live slot");

endmodule

// ===== design/lcttl_order.sv =====
// recency order matrix: tracks which slot was used more recently than which
// and picks the least recently used live slot; uses no package items
module lcttl_order #(
    parameter int ENTRIES = 16
) (
    input  logic               i_clk,
    input  logic [ENTRIES-1:0] i_live,
    input  logic [ENTRIES-1:0] i_touch,
    output logic [ENTRIES-1:0] o_lru
);

    // r_newer[i][j] set: slot i was used after slot j
    logic [ENTRIES-1:0] r_newer [ENTRIES];

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < ENTRIES; i++) begin
            for (int j = 0; j < ENTRIES; j++) begin
                if (i_touch[i]) begin
                    r_newer[i][j] <= (i != j);
                end else if (i_touch[j]) begin
                    r_newer[i][j] <= 1'b0;
                end
            end
        end
    end

    // the oldest live slot is newer than no other live slot
    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            o_lru[i] = i_live[i] && ((r_newer[i] & i_live) == '0);
        end
    end

endmodule
